// ----- sv/mtma_pkg.sv -----
// shared constants and control types of the 4x4 tile multiply-accumulate unit
package mtma_pkg;

  localparam int unsigned TILE  = 4;
  localparam int unsigned NSUMS = TILE * TILE;
  localparam int unsigned POS_W = 2;
  localparam int unsigned IDX_W = 2 * POS_W;
  localparam int unsigned CNT_W = IDX_W + 1;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NSUMS - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NSUMS);

  typedef struct packed {
    logic cap;
    logic upd;
    logic clr;
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

// ----- sv/mtma_cell.sv -----
// one multiply-accumulate cell with its slot of the shifting result chain
module mtma_cell #(
  parameter int unsigned ACC_BITS     = 48,
  parameter int unsigned OPERAND_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mtma_pkg::cell_ctrl_t           ctrl_i,
  input  logic signed [OPERAND_BITS-1:0] a_i,
  input  logic signed [OPERAND_BITS-1:0] b_i,
  input  logic signed [ACC_BITS-1:0]     shd_sum_i,
  input  logic                           shd_sat_i,
  output logic signed [ACC_BITS-1:0]     shd_sum_o,
  output logic                           shd_sat_o
);

  localparam int unsigned PROD_W = 2 * OPERAND_BITS;
  localparam int unsigned EXT_W  = ((ACC_BITS > PROD_W) ? ACC_BITS : PROD_W) + 1;
  localparam logic signed [EXT_W-1:0] HI = EXT_W'({1'b0, {(ACC_BITS-1){1'b1}}});
  localparam logic signed [EXT_W-1:0] LO = ~HI;

  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic signed [ACC_BITS-1:0] acc_d, acc_q, base;
  logic                       sat_d, sat_q, base_sat;
  logic signed [EXT_W-1:0]    sum_ext;
  logic signed [ACC_BITS-1:0] sum_clamped;
  logic                       clip;
  logic signed [ACC_BITS-1:0] shd_sum_d, shd_sum_q;
  logic                       shd_sat_d, shd_sat_q;

  assign prod_d   = a_i * b_i;
  assign base     = ctrl_i.clr ? '0 : acc_q;
  assign base_sat = ctrl_i.clr ? 1'b0 : sat_q;
  assign sum_ext  = EXT_W'(base) + EXT_W'(prod_q);

  always_comb begin
    if (sum_ext > HI) begin
      sum_clamped = HI[ACC_BITS-1:0];
      clip        = 1'b1;
    end else if (sum_ext < LO) begin
      sum_clamped = LO[ACC_BITS-1:0];
      clip        = 1'b1;
    end else begin
      sum_clamped = sum_ext[ACC_BITS-1:0];
      clip        = 1'b0;
    end
  end

  assign acc_d = ctrl_i.upd ? sum_clamped : acc_q;
  assign sat_d = ctrl_i.upd ? (base_sat | clip) : sat_q;

  always_comb begin
    shd_sum_d = shd_sum_q;
    shd_sat_d = shd_sat_q;
    if (ctrl_i.load) begin
      shd_sum_d = acc_d;
      shd_sat_d = sat_d;
    end else if (ctrl_i.shift) begin
      shd_sum_d = shd_sum_i;
      shd_sat_d = shd_sat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      sat_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      sat_q <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap) begin
      prod_q <= prod_d;
    end
    shd_sum_q <= shd_sum_d;
    shd_sat_q <= shd_sat_d;
  end

  assign shd_sum_o = shd_sum_q;
  assign shd_sat_o = shd_sat_q;

endmodule

// ----- sv/matrix_tile_multiply_accumulate_unit.sv -----
// top level: 4x4 tile outer-product multiply-accumulate over a row of 16 cells
//
// channel  dir  tdata                                   tuser       tlast
// s_axis   in   a_elem0..3, b_elem0..3 (OPERAND_BITS)   first_step  last_step
// m_axis   out  tile_row, tile_col, sum_value           saturated   end_of_tile
//
// one k step is taken per cycle while s_axis is not stalled; products are
// registered, then added into the 16 accumulators from that product register
// a last step copies the sums into the shift chain, which drains one word a
// cycle while m_axis_tready is high
// s_axis stalls only while a last step waits for the chain to empty
// reset clears accumulators, clip flags and the chain count
module matrix_tile_multiply_accumulate_unit #(
  parameter int unsigned ACC_BITS     = 48,
  parameter int unsigned OPERAND_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // a_elem0, a_elem1, a_elem2, a_elem3, b_elem0, b_elem1, b_elem2, b_elem3
  input  logic [8*OPERAND_BITS-1:0]             s_axis_tdata_i,
  // first_step
  input  logic                                  s_axis_tuser_i,
  input  logic                                  s_axis_tlast_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // tile_row, tile_col, sum_value, zero fill
  output logic [((ACC_BITS+mtma_pkg::IDX_W+7)/8)*8-1:0] m_axis_tdata_o,
  // saturated
  output logic                                  m_axis_tuser_o,
  output logic                                  m_axis_tlast_o
);

  localparam int unsigned OUT_W = ((ACC_BITS + mtma_pkg::IDX_W + 7) / 8) * 8;

  logic                         in_acc, out_acc, stall, chain_free;
  logic                         s1_valid_q, s1_first_q, s1_last_q;
  logic [mtma_pkg::CNT_W-1:0]   cnt_q;
  logic [mtma_pkg::IDX_W-1:0]   idx_q;
  mtma_pkg::cell_ctrl_t         ctrl;

  logic signed [OPERAND_BITS-1:0] a_op [mtma_pkg::TILE];
  logic signed [OPERAND_BITS-1:0] b_op [mtma_pkg::TILE];
  logic signed [ACC_BITS-1:0]     shd_sum [mtma_pkg::NSUMS+1];
  logic                           shd_sat [mtma_pkg::NSUMS+1];

  assign chain_free = (cnt_q == '0) ||
                      ((cnt_q == mtma_pkg::CNT_W'(1)) && m_axis_tready_i);
  assign stall      = s1_valid_q && s1_last_q && !chain_free;

  assign s_axis_tready_o = !stall;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc         = m_axis_tvalid_o && m_axis_tready_i;

  assign ctrl.cap   = in_acc;
  assign ctrl.upd   = s1_valid_q && !stall;
  assign ctrl.clr   = s1_first_q;
  assign ctrl.load  = s1_valid_q && !stall && s1_last_q;
  assign ctrl.shift = out_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      cnt_q      <= '0;
      idx_q      <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        s1_first_q <= s_axis_tuser_i;
        s1_last_q  <= s_axis_tlast_i;
      end else if (ctrl.upd) begin
        s1_valid_q <= 1'b0;
      end
      if (ctrl.load) begin
        cnt_q <= mtma_pkg::CNT_FULL;
        idx_q <= '0;
      end else if (out_acc) begin
        cnt_q <= cnt_q - mtma_pkg::CNT_W'(1);
        idx_q <= idx_q + mtma_pkg::IDX_W'(1);
      end
    end
  end

  for (genvar k = 0; k < mtma_pkg::TILE; k++) begin : g_ops
    assign a_op[k] = s_axis_tdata_i[k*OPERAND_BITS +: OPERAND_BITS];
    assign b_op[k] = s_axis_tdata_i[(k+mtma_pkg::TILE)*OPERAND_BITS +: OPERAND_BITS];
  end

  assign shd_sum[mtma_pkg::NSUMS] = '0;
  assign shd_sat[mtma_pkg::NSUMS] = 1'b0;

  for (genvar i = 0; i < mtma_pkg::NSUMS; i++) begin : g_cell
    mtma_cell #(
      .ACC_BITS     (ACC_BITS),
      .OPERAND_BITS (OPERAND_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .a_i       (a_op[i / mtma_pkg::TILE]),
      .b_i       (b_op[i % mtma_pkg::TILE]),
      .shd_sum_i (shd_sum[i+1]),
      .shd_sat_i (shd_sat[i+1]),
      .shd_sum_o (shd_sum[i]),
      .shd_sat_o (shd_sat[i])
    );
  end

  // idx_q holds row in its upper half and column in its lower half
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = OUT_W'({shd_sum[0],
                                   idx_q[mtma_pkg::POS_W-1:0],
                                   idx_q[mtma_pkg::IDX_W-1:mtma_pkg::POS_W]});
  assign m_axis_tuser_o  = shd_sat[0];
  assign m_axis_tlast_o  = (idx_q == mtma_pkg::IDX_LAST);

endmodule

// ----- sv/mtma_checker.sv -----
// port-level checks of the tile multiply-accumulate unit and their binding
module mtma_checker #(
  parameter int unsigned ACC_BITS = 48
) (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  s_axis_tready_o,
  input logic                                  m_axis_tvalid_o,
  input logic                                  m_axis_tready_i,
  input logic [((ACC_BITS+mtma_pkg::IDX_W+7)/8)*8-1:0] m_axis_tdata_o,
  input logic                                  m_axis_tuser_o,
  input logic                                  m_axis_tlast_o
);

  logic                       out_acc;
  logic [mtma_pkg::IDX_W-1:0] out_idx;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;
  // row-major index: row in the upper half, column in the lower half
  assign out_idx = {m_axis_tdata_o[mtma_pkg::POS_W-1:0],
                    m_axis_tdata_o[mtma_pkg::IDX_W-1:mtma_pkg::POS_W]};

  // held word on a stalled output
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output word changed while stalled");

  // tlast marks exactly the sixteenth sum
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tlast_o == (out_idx == mtma_pkg::IDX_LAST)))
    else $error("tlast not on the final sum");

  // a tile drains without gaps in row-major order
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !m_axis_tlast_o |=>
      m_axis_tvalid_o && (out_idx == $past(out_idx) + mtma_pkg::IDX_W'(1)))
    else $error("sum order broken");

  // input only back-pressured while sums are still draining
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with empty output");

endmodule

bind matrix_tile_multiply_accumulate_unit mtma_checker #(
  .ACC_BITS (ACC_BITS)
) u_mtma_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
